>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with an active-low reset
`define ASSERT_CLKED(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// assertion on the block clock and reset
`define ASSERT_BLK(label, prop, msg) \
  `ASSERT_CLKED(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/sgr_pkg.sv
// types and constants of the styled glyph row generator
package sgr_pkg;

  localparam int unsigned RowW = 5;
  localparam int unsigned PixW = 32;

  localparam logic [RowW-1:0] RowFirst   = 5'd0;
  localparam logic [RowW-1:0] RowLast    = 5'd31;
  localparam logic [RowW-1:0] RowStrikeA = 5'd14;
  localparam logic [RowW-1:0] RowStrikeB = 5'd15;
  localparam logic [RowW-1:0] RowUnderA  = 5'd28;
  localparam logic [RowW-1:0] RowUnderB  = 5'd29;

  localparam logic [7:0] KeyItalic    = 8'h2F;
  localparam logic [7:0] KeyStrike    = 8'h5D;
  localparam logic [7:0] KeyUnderline = 8'h5B;
  localparam logic [7:0] KeyBold      = 8'h2A;

  localparam logic [PixW-1:0] BorderMask = 32'h7FFF_FFFE;
  localparam logic [PixW-1:0] BoldMask   = 32'hFFFF_FFFC;
  localparam logic [PixW-1:0] UnderMask  = 32'h3FFF_FFFC;
  localparam logic [PixW-1:0] AllOnes    = 32'hFFFF_FFFF;

  // italic band masks: shifted part and kept part
  localparam logic [PixW-1:0] Ital0Shift = 32'hFFFF_FFC0;
  localparam logic [PixW-1:0] Ital0Keep  = 32'h0000_003F;
  localparam logic [PixW-1:0] Ital1Shift = 32'hFFFF_FFF8;
  localparam logic [PixW-1:0] Ital1Keep  = 32'h0000_0007;
  localparam logic [PixW-1:0] Ital2Shift = 32'h1FFF_FFFF;
  localparam logic [PixW-1:0] Ital2Keep  = 32'hE000_0000;
  localparam logic [PixW-1:0] Ital3Shift = 32'h03FF_FFFF;
  localparam logic [PixW-1:0] Ital3Keep  = 32'hFC00_0000;

  localparam logic [1:0] Band0 = 2'd0;
  localparam logic [1:0] Band1 = 2'd1;
  localparam logic [1:0] Band2 = 2'd2;
  localparam logic [1:0] Band3 = 2'd3;

  typedef struct packed {
    logic bold;
    logic italic;
    logic strike;
    logic underline;
  } sgr_style_t;

endpackage

>>> rtl/styled_glyph_row_generator.sv
// top level: glyph store, row sequencer and shared styling unit
// load and style-toggle words do not start the sequencer; busy stays low for them
// a glyph key reads one store row per cycle: accept starts the sequencer,
// each row passes the store read and output registers, 32 rows in all
// the single store read port and the one styling unit set that rate
// reset clears the style flags and the sequencer; the store is not cleared
`include "assert_macros.svh"

module styled_glyph_row_generator import sgr_pkg::*; #(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            kind_i,
  input  logic [7:0]      char_code_i,
  input  logic [RowW-1:0] row_index_i,
  input  logic [PixW-1:0] row_data_i,
  output logic            strobe_o,
  output logic [PixW-1:0] pixel_row_o,
  output logic [RowW-1:0] row_number_o,
  output logic            last_row_o
);

  localparam int unsigned Depth = GLYPH_COUNT * 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [8:0]  GlyphLim = 9'(GLYPH_COUNT);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_q, state_d;
  logic [RowW-1:0] rd_row_q, rd_row_d;
  logic [7:0]      code_q;
  logic            oob_q;
  sgr_style_t      style_q, style_d;

  // stage 1: store data for row s1_row_q is on the read port
  logic            s1_q;
  logic [RowW-1:0] s1_row_q;
  logic [PixW-1:0] prev_q;

  // output stage
  logic            strobe_q;
  logic [PixW-1:0] pix_q;
  logic [RowW-1:0] row_q;
  logic            last_q;

  logic            accept;
  logic            in_range;
  logic            is_style;
  logic            glyph_go;
  logic            mem_we;
  logic            mem_re;
  logic [PixW-1:0] rdata;
  logic [PixW-1:0] cur;
  logic [PixW-1:0] styled;

  // a word is taken whenever the block is not walking a glyph
  assign busy     = (state_q == ST_READ) | s1_q;
  assign accept   = start & ~busy;
  assign in_range = {1'b0, char_code_i} < GlyphLim;
  assign is_style = (char_code_i == KeyItalic) || (char_code_i == KeyStrike) ||
                    (char_code_i == KeyUnderline) || (char_code_i == KeyBold);
  assign glyph_go = accept & kind_i & ~is_style;

  // loads beyond the store are dropped
  assign mem_we = accept & ~kind_i & in_range;
  assign mem_re = (state_q == ST_READ);

  sgr_glyph_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'({char_code_i, row_index_i})),
    .wdata_i (row_data_i),
    .re_i    (mem_re),
    .raddr_i (AddrW'({code_q, rd_row_q})),
    .rdata_o (rdata)
  );

  // codes past the store read as blank rows
  assign cur = oob_q ? '0 : rdata;

  sgr_style u_style (
    .cur_i   (cur),
    .prev_i  (prev_q),
    .row_i   (s1_row_q),
    .style_i (style_q),
    .row_o   (styled)
  );

  // style flag toggles
  always_comb begin
    style_d = style_q;
    if (accept && kind_i) begin
      unique case (1'b1)
        (char_code_i == KeyItalic):    style_d.italic    = ~style_q.italic;
        (char_code_i == KeyStrike):    style_d.strike    = ~style_q.strike;
        (char_code_i == KeyUnderline): style_d.underline = ~style_q.underline;
        (char_code_i == KeyBold):      style_d.bold      = ~style_q.bold;
        default: style_d = style_q;
      endcase
    end
  end

  // row read sequencer
  always_comb begin
    state_d  = state_q;
    rd_row_d = rd_row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (glyph_go) begin
          state_d  = ST_READ;
          rd_row_d = RowFirst;
        end
      end
      ST_READ: begin
        rd_row_d = rd_row_q + 5'd1;
        if (rd_row_q == RowLast) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_row_q <= '0;
      style_q  <= '0;
      s1_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_row_q <= rd_row_d;
      style_q  <= style_d;
      s1_q     <= mem_re;
      strobe_q <= s1_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (glyph_go) begin
      code_q <= char_code_i;
      oob_q  <= ~in_range;
    end
    if (mem_re) begin
      s1_row_q <= rd_row_q;
    end
    if (s1_q) begin
      prev_q <= cur;
      pix_q  <= styled;
      row_q  <= s1_row_q;
      last_q <= (s1_row_q == RowLast);
    end
  end

  assign strobe_o     = strobe_q;
  assign pixel_row_o  = pix_q;
  assign row_number_o = row_q;
  assign last_row_o   = last_q;

  // rows of a glyph come back to back and in order
  `ASSERT_BLK(a_rows_contiguous, strobe_o && !last_row_o |=> strobe_o && row_number_o == $past(row_number_o) + 5'd1, "glyph rows not contiguous")
  // the last row frees the block
  `ASSERT_BLK(a_last_frees, strobe_o && last_row_o |-> !busy, "busy after last row")
  // a glyph key holds the block off
  `ASSERT_BLK(a_glyph_busy, glyph_go |=> busy && !strobe_o, "glyph key did not start")
  // style flags hold while rows are produced
  `ASSERT_BLK(a_style_stable, busy |=> $stable(style_q), "style changed mid glyph")

endmodule

>>> rtl/sgr_glyph_mem.sv
// glyph row store, one write and one registered read port
module sgr_glyph_mem import sgr_pkg::*; #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [PixW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [PixW-1:0]  rdata_o
);

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sgr_style.sv
// row styling unit, shared by all rows of a glyph
module sgr_style import sgr_pkg::*; (
  input  logic [PixW-1:0] cur_i,
  input  logic [PixW-1:0] prev_i,
  input  logic [RowW-1:0] row_i,
  input  sgr_style_t      style_i,
  output logic [PixW-1:0] row_o
);

  logic [PixW-1:0] base;
  logic [PixW-1:0] ital;
  logic [PixW-1:0] strk;

  // border and bold
  always_comb begin
    base = '0;
    if (row_i == RowFirst || row_i == RowLast) begin
      base = '0;
    end else if (style_i.bold) begin
      base = cur_i | ((cur_i << 1) & BoldMask);
      if (row_i > 5'd1) begin
        base = base | prev_i;
      end
      base = base & BorderMask;
    end else begin
      base = cur_i & BorderMask;
    end
  end

  // italic slant per 8-row band
  always_comb begin
    ital = base;
    if (style_i.italic) begin
      unique case (row_i[4:3])
        Band0: ital = ((base << 4) & Ital0Shift) | (base & Ital0Keep);
        Band1: ital = ((base << 2) & Ital1Shift) | (base & Ital1Keep);
        Band2: ital = ((base >> 2) & Ital2Shift) | (base & Ital2Keep);
        Band3: ital = ((base >> 2) & Ital3Shift) | (base & Ital3Keep);
        default: ital = base;
      endcase
    end
  end

  always_comb begin
    strk = ital;
    if (style_i.strike && (row_i == RowStrikeA || row_i == RowStrikeB)) begin
      strk = AllOnes;
    end
  end

  assign row_o = (style_i.underline && (row_i == RowUnderA || row_i == RowUnderB))
                 ? (strk | UnderMask) : strk;

endmodule
